// ----- design/swcc_pkg.sv -----
// ----------------------------------------------------------------------------
// swcc_pkg
// Shared types and constants of the sliding window connection counter.
// ----------------------------------------------------------------------------
`default_nettype none

package swcc_pkg;

  // Window geometry
  localparam int WINDOW_DEPTH = 64;
  localparam int ADDR_W       = 32;
  localparam int PORT_W       = 16;
  localparam int KEY_W        = ADDR_W + PORT_W;

  // Result count field and its saturation point
  localparam int          CNT_W     = 7;
  localparam logic [6:0]  COUNT_MAX = 7'd127;

  // Adder tree: groups of eight match bits, then a sum over the groups
  localparam int GRP_SIZE = 8;
  localparam int NGRP     = (WINDOW_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W    = $clog2(GRP_SIZE + 1);
  localparam int SUM_W    = $clog2(WINDOW_DEPTH + 1);

  // Command codes
  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  // Pair of lookup keys: {src_addr, dst_port} and {dst_addr, src_port}
  typedef struct packed {
    logic [KEY_W-1:0] sd_key;
    logic [KEY_W-1:0] ds_key;
  } key_pair_t;

  // One window slot, shared by both windows
  typedef struct packed {
    logic      vld;
    key_pair_t keys;
  } entry_t;

  // Per-cycle control for the cell row
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/swcc_cell.sv -----
// ----------------------------------------------------------------------------
// swcc_cell
// One window slot. Takes its neighbor's entry on a record and compares the
// updated entry against the lookup keys of the transfer just taken.
// ----------------------------------------------------------------------------
`default_nettype none

module swcc_cell
  import swcc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    prev_i,
  input  wire key_pair_t q_i,
  output logic           vld_o,
  output key_pair_t      keys_o,
  output logic           match_sd_o,
  output logic           match_ds_o
);

  logic      vld_r;
  logic      vld_nxt;
  key_pair_t keys_r;
  key_pair_t keys_nxt;
  logic      match_sd_r;
  logic      match_ds_r;

  // Entry after this cycle's shift
  always_comb begin
    vld_nxt  = vld_r;
    keys_nxt = keys_r;
    if (ctl.shift) begin
      vld_nxt  = prev_i.vld;
      keys_nxt = prev_i.keys;
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Key storage and registered match flags
  always_ff @(posedge clk) begin
    keys_r <= keys_nxt;
    if (ctl.load) begin
      match_sd_r <= vld_nxt && (keys_nxt.sd_key == q_i.sd_key);
      match_ds_r <= vld_nxt && (keys_nxt.ds_key == q_i.ds_key);
    end
  end

  assign vld_o      = vld_r;
  assign keys_o     = keys_r;
  assign match_sd_o = match_sd_r;
  assign match_ds_o = match_ds_r;

endmodule

`default_nettype wire

// ----- design/swcc_count.sv -----
// ----------------------------------------------------------------------------
// swcc_count
// Two-stage registered population count over one window's match flags,
// with saturation to the result field.
// ----------------------------------------------------------------------------
`default_nettype none

module swcc_count
  import swcc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    ld_grp,
  input  wire logic                    ld_out,
  input  wire logic [WINDOW_DEPTH-1:0] match_i,
  output logic      [CNT_W-1:0]        count_o
);

  localparam int CMP_W = (SUM_W > CNT_W) ? SUM_W : CNT_W;

  logic [NGRP*GRP_SIZE-1:0] match_pad;
  logic [GRP_W-1:0]         grp_nxt [NGRP];
  logic [GRP_W-1:0]         grp_r   [NGRP];
  logic [SUM_W-1:0]         sum;
  logic [CMP_W-1:0]         sum_ext;
  logic [CNT_W-1:0]         count_nxt;
  logic [CNT_W-1:0]         count_r;

  assign match_pad = (NGRP*GRP_SIZE)'(match_i);

  // First level: eight flags per group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int b = 0; b < GRP_SIZE; b++) begin
        grp_nxt[g] = grp_nxt[g] + GRP_W'(match_pad[g*GRP_SIZE+b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_grp) begin
      grp_r <= grp_nxt;
    end
  end

  // Second level: sum of groups, then saturate
  always_comb begin
    sum = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum = sum + SUM_W'(grp_r[g]);
    end
    sum_ext = CMP_W'(sum);
    if (sum_ext > CMP_W'(COUNT_MAX)) begin
      count_nxt = COUNT_MAX;
    end else begin
      count_nxt = sum_ext[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      count_r <= count_nxt;
    end
  end

  assign count_o = count_r;

endmodule

`default_nettype wire

// ----- design/sliding_window_connection_counter_top.sv -----
// ----------------------------------------------------------------------------
// sliding_window_connection_counter_top
// Counts occurrences of connection key pairs over the last WINDOW_DEPTH
// recorded connections.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per connection event. in_tuser is the command
//           (record or query), in_tdata carries addresses and ports.
//   out_* : one transfer per input transfer, in order, carrying the two
//           match counts.
//   A record shifts both keys into the head of a row of cells; the cell at
//   the tail drops the oldest entry. Each cell compares its updated entry
//   with the lookup keys in the cycle of the transfer.
//   An item passes registered match flags, group sums of eight and final
//   sum on its way to out_tvalid. Throughput is one item per cycle while
//   out_tready holds high, with the whole cell row compared at once.
//   When out_tready is low the result waits in the output register while
//   the two inner stages keep filling; in_tready drops once all three hold
//   an item.
//   Reset clears all cell valid bits at once (empty windows) and the stage
//   valid flags; the block takes transfers in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_connection_counter_top
  import swcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: src_addr[31:0], src_port[47:32], dst_addr[79:48], dst_port[95:80]
  input  wire logic [95:0] in_tdata,
  // in_tuser: cmd[0]
  input  wire logic        in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: src_dst_count[6:0], dst_src_count[13:7], zero pad[15:14]
  output logic [15:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  logic [ADDR_W-1:0] src_addr;
  logic [PORT_W-1:0] src_port;
  logic [ADDR_W-1:0] dst_addr;
  logic [PORT_W-1:0] dst_port;
  cmd_t              cmd;
  key_pair_t         q_keys;
  entry_t            new_entry;
  cell_ctl_t         ctl;

  entry_t                  chain_in [WINDOW_DEPTH];
  entry_t                  win      [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] match_sd;
  logic [WINDOW_DEPTH-1:0] match_ds;

  logic s1_vld_r, s1_vld_nxt;
  logic s2_vld_r, s2_vld_nxt;
  logic out_vld_r, out_vld_nxt;
  logic out_free, s2_free, s1_free;
  logic adv2, adv3, in_acc;

  logic [CNT_W-1:0] sd_count;
  logic [CNT_W-1:0] ds_count;

  // Field unpacking and keys
  assign src_addr  = in_tdata[31:0];
  assign src_port  = in_tdata[47:32];
  assign dst_addr  = in_tdata[79:48];
  assign dst_port  = in_tdata[95:80];
  assign cmd       = cmd_t'(in_tuser);
  assign q_keys    = '{sd_key: {src_addr, dst_port}, ds_key: {dst_addr, src_port}};
  assign new_entry = '{vld: 1'b1, keys: q_keys};

  // Pipeline flow control
  assign out_free  = !out_vld_r || out_tready;
  assign adv3      = s2_vld_r && out_free;
  assign s2_free   = !s2_vld_r || adv3;
  assign adv2      = s1_vld_r && s2_free;
  assign s1_free   = !s1_vld_r || adv2;
  assign in_tready = s1_free;
  assign in_acc    = in_tvalid && in_tready;

  assign ctl.shift = in_acc && (cmd == CMD_RECORD);
  assign ctl.load  = in_acc;

  // Cell row
  assign chain_in[0] = new_entry;
  for (genvar i = 1; i < WINDOW_DEPTH; i++) begin : g_link
    assign chain_in[i] = win[i-1];
  end

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    swcc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_i     (chain_in[i]),
      .q_i        (q_keys),
      .vld_o      (win[i].vld),
      .keys_o     (win[i].keys),
      .match_sd_o (match_sd[i]),
      .match_ds_o (match_ds[i])
    );
  end

  // Counters, one per window
  swcc_count u_cnt_sd (
    .clk     (clk),
    .ld_grp  (adv2),
    .ld_out  (adv3),
    .match_i (match_sd),
    .count_o (sd_count)
  );

  swcc_count u_cnt_ds (
    .clk     (clk),
    .ld_grp  (adv2),
    .ld_out  (adv3),
    .match_i (match_ds),
    .count_o (ds_count)
  );

  // Stage valid flags
  always_comb begin
    s1_vld_nxt  = in_acc ? 1'b1 : (adv2 ? 1'b0 : s1_vld_r);
    s2_vld_nxt  = adv2   ? 1'b1 : (adv3 ? 1'b0 : s2_vld_r);
    out_vld_nxt = adv3   ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, ds_count, sd_count};

  // Checks
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_vld_r && s2_vld_r && out_vld_r))
    else $error("input stalled while a pipeline stage is empty");

  a_record_head: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd == CMD_RECORD)) |=> win[0].vld)
    else $error("recorded entry missing at head cell");

  a_self_match: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd == CMD_RECORD)) |=> (match_sd[0] && match_ds[0]))
    else $error("recorded entry does not match its own keys");

endmodule

`default_nettype wire
